FILE: design/fm_chip_mute_shadow_unit_assert.svh
// Assertion macros used by the shadow unit control module.
// Both assume a clock named clk_i and an active-low reset named rst_ni.
`ifndef FM_CHIP_MUTE_SHADOW_UNIT_ASSERT_SVH
`define FM_CHIP_MUTE_SHADOW_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FMCMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FMCMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/fmcms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fmcms_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_WR_A  = 2'd0,
    CMD_WR_B  = 2'd1,
    CMD_SOUND = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam int unsigned LEVEL_DEPTH = 32;
  localparam int unsigned LEVEL_AW    = 5;
  localparam int unsigned ALGO_DEPTH  = 8;

  localparam logic [7:0] MIX_ADDR    = 8'h07;
  localparam logic [7:0] MIX_MUTED   = 8'h3f;
  localparam logic [3:0] LEVEL_HI    = 4'h4;     // 0x40-0x4F
  localparam logic [5:0] ALGO_HI     = 6'b101100; // 0xB0-0xB3
  localparam logic [6:0] LEVEL_MAX   = 7'h7f;
  localparam logic [2:0] LAST_SLOT   = 3'd5;
  localparam logic [1:0] LAST_OP     = 2'd3;

  // Level memory write port
  typedef struct packed {
    logic                en;
    logic [LEVEL_AW-1:0] addr;
    logic [6:0]          data;
  } lvl_wr_t;

  // Level memory read port
  typedef struct packed {
    logic                en;
    logic [LEVEL_AW-1:0] addr;
  } lvl_rd_t;

  // One chip write handed to the output register
  typedef struct packed {
    logic       valid;
    logic       bank;
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } emit_t;

  // Carrier operators selected by each algorithm
  function automatic logic [3:0] carrier_mask(input logic [2:0] alg);
    logic [3:0] m;
    unique case (alg)
      3'd4:           m = 4'hc;
      3'd5, 3'd6:     m = 4'he;
      3'd7:           m = 4'hf;
      default:        m = 4'h8;
    endcase
    return m;
  endfunction

  // Replay order of channels: 0,4,1,5,2,6
  function automatic logic [2:0] channel_of(input logic [2:0] slot);
    logic [2:0] c;
    unique case (slot)
      3'd0:    c = 3'd0;
      3'd1:    c = 3'd4;
      3'd2:    c = 3'd1;
      3'd3:    c = 3'd5;
      3'd4:    c = 3'd2;
      default: c = 3'd6;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/fmcms_level_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fmcms_level_ram
  import fmcms_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire lvl_wr_t wr_i,
  input  wire lvl_rd_t rd_i,
  output logic [6:0]   rd_data_o
);

  logic [6:0]             mem [LEVEL_DEPTH];
  logic [LEVEL_DEPTH-1:0] vld_q;
  logic [6:0]             rd_data_q;

  // Store level bytes
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Mark written entries; unwritten ones read as full attenuation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // Register read data; hold it between reads
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= vld_q[rd_i.addr] ? mem[rd_i.addr] : LEVEL_MAX;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: design/fmcms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fmcms_ctrl
  import fmcms_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] reg_addr_i,
  input  wire logic [7:0] reg_data_i,
  input  wire logic       sound_on_i,
  input  wire logic       out_free_i,
  output emit_t           emit_o,
  output lvl_wr_t         lvl_wr_o,
  output lvl_rd_t         lvl_rd_o,
  input  wire logic [6:0] lvl_rd_data_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_READ = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] slot_q, slot_d;
  logic [1:0] op_q, op_d;
  logic       on_q;
  logic [7:0] mix_q;
  logic [2:0] algo_q [ALGO_DEPTH];

  cmd_e       cmd;
  logic       accept;
  logic       is_wr;
  logic       bank;
  logic       hit_mix;
  logic       hit_level;
  logic       hit_algo;
  logic [2:0] ch;
  logic [3:0] mask;
  logic       step_last;

  assign cmd        = cmd_e'(cmd_i);
  assign in_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_wr      = (cmd == CMD_WR_A) || (cmd == CMD_WR_B);
  assign bank       = cmd_i[0];

  // Decode shadowed registers
  assign hit_mix   = !bank && (reg_addr_i == MIX_ADDR);
  assign hit_level = reg_addr_i[7:4] == LEVEL_HI;
  assign hit_algo  = reg_addr_i[7:2] == ALGO_HI;

  // Record total levels in the level memory
  always_comb begin
    lvl_wr_o.en   = accept && is_wr && hit_level;
    lvl_wr_o.addr = {bank, reg_addr_i[3:0]};
    lvl_wr_o.data = reg_data_i[6:0];
  end

  // Record algorithm and PSG mix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q <= MIX_MUTED;
      for (int i = 0; i < ALGO_DEPTH; i++) begin
        algo_q[i] <= '0;
      end
    end else if (accept && is_wr) begin
      if (hit_mix) begin
        mix_q <= reg_data_i;
      end else if (hit_algo) begin
        algo_q[{bank, reg_addr_i[1:0]}] <= reg_data_i[2:0];
      end
    end
  end

  // Current replay step: channel, carrier mask, final write
  assign ch        = channel_of(slot_q);
  assign mask      = carrier_mask(algo_q[ch]);
  assign step_last = (slot_q == LAST_SLOT) && (op_q == LAST_OP);

  // Sequence writes and the replay walk
  always_comb begin
    state_d       = state_q;
    slot_d        = slot_q;
    op_d          = op_q;
    lvl_rd_o.en   = 1'b0;
    lvl_rd_o.addr = {ch[2], op_q, ch[1:0]};
    emit_o        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_wr) begin
            emit_o = '{valid: 1'b1, bank: bank, addr: reg_addr_i,
                       data: reg_data_i, last: 1'b1};
          end else if (cmd == CMD_SOUND) begin
            emit_o = '{valid: 1'b1, bank: 1'b0, addr: MIX_ADDR,
                       data: sound_on_i ? mix_q : MIX_MUTED, last: 1'b0};
            state_d = S_SCAN;
            slot_d  = '0;
            op_d    = '0;
          end
        end
      end
      S_SCAN: begin
        if (mask[op_q]) begin
          lvl_rd_o.en = 1'b1;
          state_d     = S_READ;
        end else begin
          op_d = op_q + 2'd1;
          if (op_q == LAST_OP) begin
            slot_d = slot_q + 3'd1;
          end
        end
      end
      S_READ: begin
        if (out_free_i) begin
          // Muting adds 127 and clamps, which always lands at full attenuation
          emit_o = '{valid: 1'b1, bank: ch[2], addr: {LEVEL_HI, op_q, ch[1:0]},
                     data: {1'b0, on_q ? lvl_rd_data_i : LEVEL_MAX},
                     last: step_last};
          if (step_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_SCAN;
            op_d    = op_q + 2'd1;
            if (op_q == LAST_OP) begin
              slot_d = slot_q + 3'd1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      op_q    <= '0;
      on_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      op_q    <= op_d;
      if (accept && (cmd == CMD_SOUND)) begin
        on_q <= sound_on_i;
      end
    end
  end

  `include "fm_chip_mute_shadow_unit_assert.svh"

  `FMCMS_ASSERT_IMP(a_emit_free, emit_o.valid, out_free_i, "emit into occupied output")
  `FMCMS_ASSERT_IMP(a_wr_idle, lvl_wr_o.en, state_q == S_IDLE, "level write during replay")
  `FMCMS_ASSERT_NXT(a_rd_wait, lvl_rd_o.en, state_q == S_READ, "read not followed by wait")
  `FMCMS_ASSERT_NXT(a_last_idle, emit_o.valid && emit_o.last, state_q == S_IDLE,
                    "final write did not end transaction")

endmodule

`default_nettype wire

FILE: design/fm_chip_mute_shadow_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Register-write front end for a two-bank FM chip. A bank A or bank B write
// is passed on as one chip write, loaded into the output register at the edge
// it is accepted, and shadows the total-level, algorithm and bank A PSG mix
// registers on the way. A sound command loads the PSG mix write at
// acceptance, then walks channels 0,4,1,5,2,6 over four operator steps each:
// a scan state for each step, plus a read state for each carrier whose level
// is fetched from the level memory, which registers its read data. A sound
// command thus yields 7 to 25 chip writes, a plain write one; output stalls
// delay both. The unit accepts the next transaction once the walk is done and
// the output register is free or being drained. Level memory entries are
// tracked by valid bits cleared at reset, so no clearing pass is needed.
module fm_chip_mute_shadow_unit
  import fmcms_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] reg_addr_i,
  input  wire logic [7:0] reg_data_i,
  input  wire logic       sound_on_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            out_bank_o,
  output logic [7:0]      out_addr_o,
  output logic [7:0]      out_data_o,
  output logic            last_o
);

  emit_t      emit;
  lvl_wr_t    lvl_wr;
  lvl_rd_t    lvl_rd;
  logic [6:0] lvl_rd_data;
  logic       out_free;
  logic       out_valid_q;
  logic       out_bank_q;
  logic [7:0] out_addr_q;
  logic [7:0] out_data_q;
  logic       last_q;

  assign out_free = !out_valid_q || out_ready_i;

  fmcms_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .reg_addr_i    (reg_addr_i),
    .reg_data_i    (reg_data_i),
    .sound_on_i    (sound_on_i),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .lvl_wr_o      (lvl_wr),
    .lvl_rd_o      (lvl_rd),
    .lvl_rd_data_i (lvl_rd_data)
  );

  fmcms_level_ram u_level_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (lvl_wr),
    .rd_i      (lvl_rd),
    .rd_data_o (lvl_rd_data)
  );

  // Hold the output transaction until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_bank_q <= emit.bank;
      out_addr_q <= emit.addr;
      out_data_q <= emit.data;
      last_q     <= emit.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_bank_o  = out_bank_q;
  assign out_addr_o  = out_addr_q;
  assign out_data_o  = out_data_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
